### rtl/core/wkre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wkre_pkg: shared types and helpers for the white key run edge alpha block
// Pixel, queue entry and alpha register types, register indexes and the
// alpha selection function.
// ----------------------------------------------------------------------------
package wkre_pkg;

    localparam int unsigned CfgIdxW  = 8;
    localparam int unsigned AlphaW   = 8;
    localparam int unsigned QDepth   = 4;
    localparam int unsigned QPtrW    = $clog2(QDepth);
    localparam int unsigned QCntW    = $clog2(QDepth + 1);

    localparam logic [CfgIdxW-1:0] CFG_EDGE_ALPHA       = 8'd0;
    localparam logic [CfgIdxW-1:0] CFG_NEAR_EDGE_ALPHA  = 8'd1;
    localparam logic [CfgIdxW-1:0] CFG_SOLID_ALPHA      = 8'd2;
    localparam logic [CfgIdxW-1:0] CFG_BACKGROUND_ALPHA = 8'd3;

    localparam logic [AlphaW-1:0] RST_EDGE_ALPHA       = 8'd92;
    localparam logic [AlphaW-1:0] RST_NEAR_EDGE_ALPHA  = 8'd64;
    localparam logic [AlphaW-1:0] RST_SOLID_ALPHA      = 8'hFF;
    localparam logic [AlphaW-1:0] RST_BACKGROUND_ALPHA = 8'd0;

    localparam logic [7:0] WHITE_LEVEL = 8'hFF;

    // position of a pixel in its run
    typedef enum logic [1:0] {
        IDX_FIRST  = 2'd0,
        IDX_SECOND = 2'd1,
        IDX_INNER  = 2'd2,
        IDX_WHITE  = 2'd3
    } run_idx_t;

    // distance to the end of the run
    typedef enum logic [1:0] {
        DIST_LAST         = 2'd0,
        DIST_NEXT_TO_LAST = 2'd1,
        DIST_FAR          = 2'd2
    } dist_t;

    // red in the lowest bits
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        logic     row_end;
        run_idx_t idx;
        pixel_t   pix;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic [AlphaW-1:0] edge_alpha;
        logic [AlphaW-1:0] near_edge_alpha;
        logic [AlphaW-1:0] solid_alpha;
        logic [AlphaW-1:0] background_alpha;
    } alpha_cfg_t;

    function automatic logic [AlphaW-1:0] pick_alpha(input run_idx_t   idx,
                                                    input dist_t      run_dist,
                                                    input alpha_cfg_t cfg);
        logic [AlphaW-1:0] a;
        if (idx == IDX_WHITE) begin
            a = cfg.background_alpha;
        end else if (idx == IDX_FIRST || run_dist == DIST_LAST) begin
            a = cfg.edge_alpha;
        end else if (idx == IDX_SECOND) begin
            a = (run_dist == DIST_FAR) ? cfg.near_edge_alpha : cfg.solid_alpha;
        end else if (run_dist == DIST_NEXT_TO_LAST) begin
            a = cfg.near_edge_alpha;
        end else begin
            a = cfg.solid_alpha;
        end
        return a;
    endfunction

endpackage

### rtl/core/white_key_run_edge_alpha_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// white_key_run_edge_alpha_top: white key to RGBA with run edge shading
// Converts a raster RGB pixel stream into RGBA, shading run edges.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ stream one per transaction, red in the lowest byte,
// with s_tlast marking the last pixel of a row. Pure white pixels get the
// background alpha; each run of non-white pixels gets the edge alpha on its
// first and last pixels, the near-edge alpha on its second and second-to-last
// pixels when the run is longer than three, and the solid alpha elsewhere.
// Colour passes through. Results trail the input by two pixels and the window
// is drained at each row end, m_tlast marking the row's final result. The
// classifier takes one pixel per cycle while the queue has room; the emitter
// produces one result per cycle while its output is not stalled and, at each
// row end, drains the pixels left in its two-pixel window without popping
// the queue. A four-entry queue between the two absorbs this. Each pixel
// passes through the queue and the output register. Alpha registers are
// written through the cfg_ port (index 0 edge, 1 near-edge, 2 solid,
// 3 background); other indexes are ignored. Write them only while the block
// is idle.
// ----------------------------------------------------------------------------
module white_key_run_edge_alpha_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input pixel stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,   // in_red, in_green, in_blue
    input  logic                          s_tlast,   // row_end
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // out_red, out_green, out_blue,
                                                     // out_alpha
    output logic                          m_tlast,   // out_row_end
    // register write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wkre_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [wkre_pkg::AlphaW-1:0]   cfg_data
);

    wkre_pkg::alpha_cfg_t cfg_reg, cfg_next;
    wkre_pkg::q_status_t  q_status;
    wkre_pkg::q_entry_t   push_entry, head;
    logic                 push, pop;

    // Always take register writes; unknown indexes drop.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                wkre_pkg::CFG_EDGE_ALPHA:       cfg_next.edge_alpha       = cfg_data;
                wkre_pkg::CFG_NEAR_EDGE_ALPHA:  cfg_next.near_edge_alpha  = cfg_data;
                wkre_pkg::CFG_SOLID_ALPHA:      cfg_next.solid_alpha      = cfg_data;
                wkre_pkg::CFG_BACKGROUND_ALPHA: cfg_next.background_alpha = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.edge_alpha       <= wkre_pkg::RST_EDGE_ALPHA;
            cfg_reg.near_edge_alpha  <= wkre_pkg::RST_NEAR_EDGE_ALPHA;
            cfg_reg.solid_alpha      <= wkre_pkg::RST_SOLID_ALPHA;
            cfg_reg.background_alpha <= wkre_pkg::RST_BACKGROUND_ALPHA;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Classify: white test and run position, one pixel per cycle while the queue has room.
    wkre_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    // Decouple: hold classified pixels while the emitter drains a row.
    wkre_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    // Emit: two-pixel lookahead, alpha choice, registered output.
    wkre_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### rtl/core/wkre_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wkre_front: input classifier
// Accepts pixels, marks white ones and tags each with its run position.
// ----------------------------------------------------------------------------
module wkre_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [23:0]        s_tdata,   // red, green, blue
    input  logic               s_tlast,   // row_end
    input  wkre_pkg::q_status_t q_status,
    output logic               push,
    output wkre_pkg::q_entry_t push_entry
);

    wkre_pkg::run_idx_t last_idx_reg, last_idx_next;
    logic               row_start_reg, row_start_next;
    wkre_pkg::pixel_t   pix;
    wkre_pkg::run_idx_t idx;
    logic               white;

    assign pix      = wkre_pkg::pixel_t'(s_tdata);
    assign s_tready = !q_status.full;
    assign push     = s_tvalid && s_tready;
    assign white    = (pix.red & pix.green & pix.blue) == wkre_pkg::WHITE_LEVEL;

    always_comb begin
        if (white) begin
            idx = wkre_pkg::IDX_WHITE;
        end else if (row_start_reg) begin
            idx = wkre_pkg::IDX_FIRST;
        end else begin
            unique case (last_idx_reg)
                wkre_pkg::IDX_FIRST:  idx = wkre_pkg::IDX_SECOND;
                wkre_pkg::IDX_SECOND: idx = wkre_pkg::IDX_INNER;
                wkre_pkg::IDX_INNER:  idx = wkre_pkg::IDX_INNER;
                default:              idx = wkre_pkg::IDX_FIRST;
            endcase
        end
    end

    assign push_entry = '{row_end: s_tlast, idx: idx, pix: pix};

    always_comb begin
        last_idx_next  = last_idx_reg;
        row_start_next = row_start_reg;
        if (push) begin
            last_idx_next  = idx;
            row_start_next = s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_idx_reg  <= wkre_pkg::IDX_FIRST;
            row_start_reg <= 1'b1;
        end else begin
            last_idx_reg  <= last_idx_next;
            row_start_reg <= row_start_next;
        end
    end

endmodule

### rtl/core/wkre_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wkre_queue: classified pixel queue
// Small first-in first-out store between the classifier and the emitter.
// ----------------------------------------------------------------------------
module wkre_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  wkre_pkg::q_entry_t  push_entry,
    input  logic                pop,
    output wkre_pkg::q_entry_t  head,
    output wkre_pkg::q_status_t status
);

    wkre_pkg::q_entry_t                 mem_reg [wkre_pkg::QDepth];
    logic [wkre_pkg::QPtrW-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [wkre_pkg::QPtrW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [wkre_pkg::QCntW-1:0]         cnt_reg, cnt_next;

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = cnt_reg == wkre_pkg::QCntW'(wkre_pkg::QDepth);
    assign status.empty = cnt_reg == '0;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + wkre_pkg::QCntW'(push) - wkre_pkg::QCntW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### rtl/core/wkre_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wkre_back: lookahead window and alpha emitter
// Holds up to two pixels awaiting lookahead, picks alpha and drives the
// registered output; drains the window at row end.
// ----------------------------------------------------------------------------
module wkre_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  wkre_pkg::alpha_cfg_t cfg,
    input  wkre_pkg::q_entry_t  head,
    input  wkre_pkg::q_status_t q_status,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,   // red, green, blue, alpha
    output logic                m_tlast    // out_row_end
);

    wkre_pkg::q_entry_t slot_reg [2];
    wkre_pkg::q_entry_t slot_next [2];
    logic [1:0]         cnt_reg, cnt_next;
    logic               flush_reg, flush_next;
    logic               m_valid_reg, m_valid_next;
    logic [31:0]        m_data_reg, m_data_next;
    logic               m_last_reg, m_last_next;

    wkre_pkg::q_entry_t v [3];
    logic [1:0]         v_n;
    logic               can_load, step, emit, row_fin;
    wkre_pkg::dist_t    run_dist;

    assign can_load = !m_valid_reg || m_tready;
    assign step     = can_load && (flush_reg || !q_status.empty);
    assign pop      = step && !flush_reg;
    assign row_fin  = flush_reg || head.row_end;

    // window: stored pixels, then the queue head unless draining
    always_comb begin
        v[0] = slot_reg[0];
        v[1] = slot_reg[1];
        v[2] = head;
        v_n  = cnt_reg;
        if (!flush_reg) begin
            v[cnt_reg] = head;
            v_n        = cnt_reg + 2'd1;
        end
    end

    assign emit = step && (row_fin || v_n == 2'd3);

    // slots beyond the window count as white
    always_comb begin
        if (v_n < 2'd2 || v[1].idx == wkre_pkg::IDX_WHITE) begin
            run_dist = wkre_pkg::DIST_LAST;
        end else if (v_n < 2'd3 || v[2].idx == wkre_pkg::IDX_WHITE) begin
            run_dist = wkre_pkg::DIST_NEXT_TO_LAST;
        end else begin
            run_dist = wkre_pkg::DIST_FAR;
        end
    end

    always_comb begin
        slot_next[0] = slot_reg[0];
        slot_next[1] = slot_reg[1];
        cnt_next     = cnt_reg;
        flush_next   = flush_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        if (emit) begin
            slot_next[0] = v[1];
            slot_next[1] = v[2];
            cnt_next     = v_n - 2'd1;
            flush_next   = row_fin && (v_n > 2'd1);
            m_valid_next = 1'b1;
            m_data_next  = {wkre_pkg::pick_alpha(v[0].idx, run_dist, cfg), 24'(v[0].pix)};
            m_last_next  = row_fin && (v_n == 2'd1);
        end else if (step) begin
            slot_next[0] = v[0];
            slot_next[1] = v[1];
            cnt_next     = v_n;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    always_ff @(posedge aclk) begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
        m_data_reg  <= m_data_next;
        m_last_reg  <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            flush_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            flush_reg   <= flush_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_flush_has_pixels: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_reg |-> cnt_reg != 2'd0)
        else $error("draining with an empty window");

    a_window_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("window holds more than two pixels");

    a_row_end_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && m_last_next) |=> (cnt_reg == 2'd0 && !flush_reg))
        else $error("window not empty after the last pixel of a row");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (can_load && !flush_reg && q_status.empty) |=> $stable(cnt_reg))
        else $error("window changed without a queued pixel");

endmodule
